// ===== sv/rmt_pkg.sv =====
// Shared word types and fixed constants for the running median tracker.
package rmt_pkg;

   // Field widths fixed by the word format.
   localparam int SAMPLE_FIELD_BITS = 32;
   localparam int MEDIAN_BITS       = 33;
   localparam int COUNT_FIELD_BITS  = 9;

   // Leaves folded into one register of the first level of the pick tree.
   localparam int PICK_GROUP = 16;

   typedef struct packed {
      logic signed [SAMPLE_FIELD_BITS-1:0] sample_value;
      logic                                restart;
   } req_word_type;

   typedef struct packed {
      logic signed [MEDIAN_BITS-1:0] median_doubled;
      logic [COUNT_FIELD_BITS-1:0]   stored_count;
      logic                          sample_dropped;
   } rsp_word_type;

endpackage

// ===== sv/rmt_cell.sv =====
// One slot of the sorted chain: holds a sample, shifts right on insert, offers median taps.
module rmt_cell #(
   parameter int SAMPLE_BITS = 32,
   parameter int COUNT_BITS  = 9,
   parameter int INDEX       = 0
) (
   input  logic                          clock,
   input  logic                          ins_en,
   input  logic signed [SAMPLE_BITS-1:0] ins_value,
   input  logic [COUNT_BITS-1:0]         fill,
   input  logic signed [SAMPLE_BITS-1:0] left_value,
   input  logic                          left_gt,
   input  logic [COUNT_BITS-1:0]         lo_idx,
   input  logic [COUNT_BITS-1:0]         hi_idx,
   output logic signed [SAMPLE_BITS-1:0] cell_value,
   output logic                          cell_gt,
   output logic [SAMPLE_BITS-1:0]        lo_pick,
   output logic [SAMPLE_BITS-1:0]        hi_pick
);

   localparam logic [COUNT_BITS-1:0] MY_INDEX = COUNT_BITS'(INDEX);

   logic signed [SAMPLE_BITS-1:0] value_ff;
   logic signed [SAMPLE_BITS-1:0] value_in;
   logic                          occupied;
   logic                          at_end;
   logic                          greater;
   logic                          take;

   assign occupied = MY_INDEX < fill;
   assign at_end   = MY_INDEX == fill;
   assign greater  = value_ff > ins_value;

   // The first free slot acts as +infinity, so the new sample can land there.
   assign take    = occupied ? greater : at_end;
   assign cell_gt = occupied && greater;

   always_comb begin
      value_in = value_ff;
      if (ins_en && take) begin
         value_in = left_gt ? left_value : ins_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_value = value_ff;
   assign lo_pick    = (MY_INDEX == lo_idx) ? value_ff : '0;
   assign hi_pick    = (MY_INDEX == hi_idx) ? value_ff : '0;

endmodule

// ===== sv/rmt_pick_tree.sv =====
// Two-level registered OR tree that collects the two median taps from the cell row.
module rmt_pick_tree #(
   parameter int LEAVES = 256,
   parameter int WIDTH  = 32
) (
   input  logic                    clock,
   input  logic [LEAVES*WIDTH-1:0] lo_leaves,
   input  logic [LEAVES*WIDTH-1:0] hi_leaves,
   output logic [WIDTH-1:0]        lo_value,
   output logic [WIDTH-1:0]        hi_value
);

   localparam int GROUPS = (LEAVES + rmt_pkg::PICK_GROUP - 1) / rmt_pkg::PICK_GROUP;
   localparam int PADDED = GROUPS * rmt_pkg::PICK_GROUP;

   logic [PADDED*WIDTH-1:0] lo_pad;
   logic [PADDED*WIDTH-1:0] hi_pad;
   logic [WIDTH-1:0]        grp_lo_in [GROUPS];
   logic [WIDTH-1:0]        grp_hi_in [GROUPS];
   logic [WIDTH-1:0]        grp_lo_ff [GROUPS];
   logic [WIDTH-1:0]        grp_hi_ff [GROUPS];
   logic [WIDTH-1:0]        lo_in;
   logic [WIDTH-1:0]        hi_in;
   logic [WIDTH-1:0]        lo_ff;
   logic [WIDTH-1:0]        hi_ff;

   assign lo_pad = (PADDED*WIDTH)'(lo_leaves);
   assign hi_pad = (PADDED*WIDTH)'(hi_leaves);

   // At most one leaf per side is nonzero, so OR acts as a select.
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_lo_in[g] = '0;
         grp_hi_in[g] = '0;
         for (int k = 0; k < rmt_pkg::PICK_GROUP; k++) begin
            grp_lo_in[g] = grp_lo_in[g] | lo_pad[(g*rmt_pkg::PICK_GROUP+k)*WIDTH +: WIDTH];
            grp_hi_in[g] = grp_hi_in[g] | hi_pad[(g*rmt_pkg::PICK_GROUP+k)*WIDTH +: WIDTH];
         end
      end
   end

   always_comb begin
      lo_in = '0;
      hi_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         lo_in = lo_in | grp_lo_ff[g];
         hi_in = hi_in | grp_hi_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      grp_lo_ff <= grp_lo_in;
      grp_hi_ff <= grp_hi_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
   end

   assign lo_value = lo_ff;
   assign hi_value = hi_ff;

endmodule

// ===== sv/running_median_tracker_top.sv =====
// Top level of the running median tracker: cell row, pick tree, control and result register.
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+-----------------------------------------
//   req     | in        | req_valid / req_ready | sample_value, restart
//   rsp     | out       | rsp_valid / rsp_ready | median_doubled, stored_count, sample_dropped
//
// Order: the cell row inserts a word at its accepting edge. The median taps then pass the two
// registered levels of the pick tree and the final add into the result register, which loads
// once it is free; only after that load is the next word taken, so words go one at a time.
// Reset: clears the fill count, the control state and the result valid; cell contents stay.
// Stalls: req may be taken while a finished result waits in the result register; a new result
// holds in the tree registers until the result register frees.
module running_median_tracker_top #(
   parameter int CAPACITY    = 256,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rmt_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rmt_pkg::rsp_word_type rsp_word
);

   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int MB         = rmt_pkg::MEDIAN_BITS;

   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(CAPACITY);

   // Control states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_TREE1 = 2'd1;
   localparam logic [1:0] ST_TREE2 = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]            state_ff;
   logic [1:0]            state_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  dropped_ff;
   logic                  dropped_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rmt_pkg::rsp_word_type rsp_word_ff;
   rmt_pkg::rsp_word_type rsp_word_in;

   logic                          req_accept;
   logic                          rsp_load;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic [COUNT_BITS-1:0]         fill;
   logic                          full;
   logic                          ins_en;
   logic [COUNT_BITS-1:0]         lo_idx;
   logic [COUNT_BITS-1:0]         hi_idx;

   logic signed [SAMPLE_BITS-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]           cell_gt;
   logic [CAPACITY*SAMPLE_BITS-1:0] lo_leaves;
   logic [CAPACITY*SAMPLE_BITS-1:0] hi_leaves;
   logic [SAMPLE_BITS-1:0]        lo_value;
   logic [SAMPLE_BITS-1:0]        hi_value;
   logic [MB-1:0]                 lo_ext;
   logic [MB-1:0]                 hi_ext;
   logic [15:0]                   count_wide;

   // Take only one word into the row at a time.
   assign req_ready  = state_ff == ST_IDLE;
   assign req_accept = req_valid && req_ready;

   // Use the low sample bits as two's complement; restart empties the row first.
   assign sample = req_word.sample_value[SAMPLE_BITS-1:0];
   assign fill   = req_word.restart ? '0 : count_ff;
   assign full   = fill >= FULL_COUNT;
   assign ins_en = req_accept && !full;

   // Median positions of the current row: equal for an odd count.
   assign lo_idx = (count_ff - COUNT_BITS'(1)) >> 1;
   assign hi_idx = count_ff >> 1;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] left_value;
      logic                          left_gt;

      if (i == 0) begin : g_head
         assign left_value = '0;
         assign left_gt    = 1'b0;
      end else begin : g_link
         assign left_value = cell_value[i-1];
         assign left_gt    = cell_gt[i-1];
      end

      rmt_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .COUNT_BITS  (COUNT_BITS),
         .INDEX       (i)
      ) u_cell (
         .clock      (clock),
         .ins_en     (ins_en),
         .ins_value  (sample),
         .fill       (fill),
         .left_value (left_value),
         .left_gt    (left_gt),
         .lo_idx     (lo_idx),
         .hi_idx     (hi_idx),
         .cell_value (cell_value[i]),
         .cell_gt    (cell_gt[i]),
         .lo_pick    (lo_leaves[i*SAMPLE_BITS +: SAMPLE_BITS]),
         .hi_pick    (hi_leaves[i*SAMPLE_BITS +: SAMPLE_BITS])
      );
   end

   rmt_pick_tree #(
      .LEAVES (CAPACITY),
      .WIDTH  (SAMPLE_BITS)
   ) u_pick_tree (
      .clock     (clock),
      .lo_leaves (lo_leaves),
      .hi_leaves (hi_leaves),
      .lo_value  (lo_value),
      .hi_value  (hi_value)
   );

   // Sum of the two middle samples is twice the median.
   assign lo_ext     = {{(MB-SAMPLE_BITS){lo_value[SAMPLE_BITS-1]}}, lo_value};
   assign hi_ext     = {{(MB-SAMPLE_BITS){hi_value[SAMPLE_BITS-1]}}, hi_value};
   assign count_wide = 16'(count_ff);

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_word_in                = rsp_word_ff;
      rsp_word_in.median_doubled = lo_ext + hi_ext;
      rsp_word_in.stored_count   = count_wide[rmt_pkg::COUNT_FIELD_BITS-1:0];
      rsp_word_in.sample_dropped = dropped_ff;
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in   = ST_TREE1;
               dropped_in = full;
               count_in   = full ? fill : fill + COUNT_BITS'(1);
            end
         end
         ST_TREE1: state_in = ST_TREE2;
         ST_TREE2: state_in = ST_DONE;
         ST_DONE: begin
            // Hold here until the result register frees.
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dropped_ff <= dropped_in;
      if (rsp_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // The fill count never passes the row length.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("fill count beyond capacity");

   // A restart always leaves exactly one sample.
   a_restart_one : assert property (@(posedge clock) disable iff (reset)
      req_accept && req_word.restart |=> count_ff == COUNT_BITS'(1))
      else $error("restart did not leave one sample");

   // A word into a full row keeps the count and is flagged.
   a_full_drop : assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_word.restart && count_ff == FULL_COUNT
      |=> count_ff == FULL_COUNT && dropped_ff)
      else $error("full row changed or drop not flagged");

   // A result is loaded only from the final state, which is then left.
   a_load_exit : assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> state_ff == ST_IDLE && rsp_valid_ff)
      else $error("result load did not return to idle");

endmodule
